// ===== hw/rtl/bpl_pkg.sv =====
package bpl_pkg;

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;
  // index field wide enough for the largest supported chain (64 cells)
  localparam int IDX_W    = 6;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // operation selector
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_READ_ALL  = 3'd6;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  // chain command
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    idx_t    idx;
    idx_t    last_idx;
    elem_t   value;
  } cell_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    elem_t             value;
    logic [POS_W-1:0]  position;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    elem_t              element;
    logic               last;
  } rsp_word_t;

endpackage

// ===== hw/rtl/bpl_stream_if.sv =====
interface bpl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bpl_cell.sv =====
module bpl_cell
  import bpl_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  elem_t     left,
  input  elem_t     right,
  input  elem_t     head,
  output elem_t     q
);

  localparam idx_t MY_IDX = IDX_W'(INDEX);

  elem_t q_next;

  // pick the next entry from the neighbors or the broadcast word
  always_comb begin
    q_next = q;
    unique case (cmd.op)
      CMD_HOLD: q_next = q;
      CMD_INS: begin
        if (MY_IDX == cmd.idx) begin
          q_next = cmd.value;
        end else if (MY_IDX > cmd.idx) begin
          q_next = left;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          q_next = right;
        end
      end
      CMD_ROT: begin
        if (MY_IDX == cmd.last_idx) begin
          q_next = head;
        end else if (MY_IDX < cmd.last_idx) begin
          q_next = right;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== hw/rtl/bounded_positional_list_top.sv =====
// Each accepted item's result word is registered in the output register.
// Insert, delete and status-only items: one item per cycle while results are taken.
// Read all: one element per cycle while results are taken; the cell chain rotates
//   one place per element and the front cell feeds the output register.
// Reset clears the element count, the read-out state and the output valid;
//   the cell contents are not cleared.
module bounded_positional_list_top
  import bpl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  bpl_stream_if.sink          req,
  bpl_stream_if.source        rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] rem, rem_next;

  logic          out_v;
  rsp_word_t     out_d;
  logic          out_free;
  logic          accept;
  logic          load;
  rsp_word_t     res;

  cell_cmd_t     cmd;
  elem_t         cell_q [CAPACITY];

  logic [WW-1:0] pos_w, cnt_w;
  logic          full;

  // build the chain of element cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_q[i+1];
    end
    bpl_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .head  (cell_q[0]),
      .q     (cell_q[i])
    );
  end

  assign out_free  = !out_v || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_v;
  assign rsp.data  = out_d;

  assign pos_w = WW'(req.data.position);
  assign cnt_w = WW'(cnt);
  assign full  = (cnt == CW'(CAPACITY));

  // decode the item, pick the chain command and form the result word
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rem_next     = rem;
    load         = 1'b0;
    cmd.op       = CMD_HOLD;
    cmd.idx      = '0;
    cmd.last_idx = IDX_W'(cnt - CW'(1));
    cmd.value    = req.data.value;
    res.status   = STAT_OK;
    res.element  = '0;
    res.last     = 1'b1;

    if (state == S_READ) begin
      if (out_free) begin
        load        = 1'b1;
        res.element = cell_q[0];
        res.last    = (rem == CW'(1));
        cmd.op      = CMD_ROT;
        rem_next    = rem - CW'(1);
        if (rem == CW'(1)) begin
          state_next = S_IDLE;
        end
      end
    end else if (accept) begin
      load = 1'b1;
      unique case (req.data.func)
        FN_INS_FRONT, FN_INS_BACK: begin
          if (full) begin
            res.status = STAT_FULL;
          end else begin
            cmd.op   = CMD_INS;
            cmd.idx  = (req.data.func == FN_INS_FRONT) ? '0 : IDX_W'(cnt);
            cnt_next = cnt + CW'(1);
          end
        end
        FN_INS_AT: begin
          if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
            res.status = STAT_BADPOS;
          end else if (full) begin
            res.status = STAT_FULL;
          end else begin
            cmd.op   = CMD_INS;
            cmd.idx  = IDX_W'(pos_w - WW'(1));
            cnt_next = cnt + CW'(1);
          end
        end
        FN_DEL_FRONT, FN_DEL_BACK: begin
          if (cnt == '0) begin
            res.status = STAT_EMPTY;
          end else begin
            cmd.op   = CMD_DEL;
            cmd.idx  = (req.data.func == FN_DEL_FRONT) ? '0 : IDX_W'(cnt - CW'(1));
            cnt_next = cnt - CW'(1);
          end
        end
        FN_DEL_AT: begin
          if (cnt == '0) begin
            res.status = STAT_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            res.status = STAT_BADPOS;
          end else begin
            cmd.op   = CMD_DEL;
            cmd.idx  = IDX_W'(pos_w - WW'(1));
            cnt_next = cnt - CW'(1);
          end
        end
        FN_READ_ALL: begin
          if (cnt == '0) begin
            res.status = STAT_EMPTY;
          end else begin
            res.element = cell_q[0];
            res.last    = (cnt == CW'(1));
            cmd.op      = CMD_ROT;
            if (cnt != CW'(1)) begin
              state_next = S_READ;
              rem_next   = cnt - CW'(1);
            end
          end
        end
        default: res.status = STAT_BADPOS;
      endcase
    end
    res.count = COUNT_W'(cnt_next);
  end

  // advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rem   <= '0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      if (load) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_d <= res;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (!req.ready && cnt != '0))
    else $error("input taken or empty list during read-out");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.func == FN_INS_FRONT && full) |=> (cnt == $past(cnt)))
    else $error("insert into full list changed the count");

  a_read_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && out_free && rem == CW'(1)) |=> (rsp.valid && rsp.data.last))
    else $error("final read-out word not marked last");

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (cnt == $past(cnt)))
    else $error("count changed during read-out");

endmodule
